[design/hav_pkg.sv]
`timescale 1ns / 1ps

package hav_pkg;

   localparam int ITERS    = 24;   // CORDIC stages per pass
   localparam int CW       = 46;   // CORDIC datapath width, Q40 signed
   localparam int QW       = 34;   // Q30 signed sine/cosine/product width
   localparam int SQ_STEPS = 31;   // one root bit per stage, root <= 2^30
   localparam int SQW      = 62;   // root radicand/remainder width

   localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
   localparam logic [32:0] ANG_M        = 33'((PI_Q60 >> 22) / 180);
   localparam logic [31:0] TURN_U23     = 32'd3019898880;
   localparam logic [31:0] QUARTER_U23  = 32'd754974720;
   localparam logic [28:0] DIST_MAX     = 29'd421657428;
   localparam logic [22:0] RADIUS_RESET = 23'd6371000;
   localparam logic [30:0] ONE_Q30      = 31'h40000000;

   // total register stages from input to output register
   localparam int DEPTH = 3 + ITERS + 1 + 3 + SQ_STEPS + ITERS + 2;

   localparam int LANE_LAT1 = 0;
   localparam int LANE_LAT2 = 1;
   localparam int LANE_DLAT = 2;
   localparam int LANE_DLON = 3;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef logic signed [CW-1:0] atan_tab_type [ITERS];

   // shift-subtract divide, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], n[b]};
         if (rem >= d) begin
            rem  = rem - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q40 from a Q60 Taylor sum
   function automatic atan_tab_type build_atan();
      atan_tab_type t;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] term;
      int e;
      t[0] = CW'((PI_Q60 + 64'd2097152) >> 22);
      for (int i = 1; i < ITERS; i++) begin
         pos = '0;
         neg = '0;
         for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
               term = udiv(64'd1 << (60 - e), 64'(2 * k + 1));
               if ((k & 1) != 0) neg = neg + term;
               else pos = pos + term;
            end
         end
         t[i] = CW'((pos - neg + 64'd524288) >> 20);
      end
      return t;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan();

   // inverse CORDIC gain, Q40
   function automatic logic signed [CW-1:0] build_gain_inv();
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] nx;
      logic [63:0] g;
      logic [63:0] rem;
      logic [63:0] gi;
      x = 64'sd1 <<< 40;
      y = '0;
      for (int i = 0; i < ITERS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
         end
         x = nx;
      end
      g   = x;
      rem = 64'd1 << 40;
      gi  = '0;
      for (int i = 0; i < 40; i++) begin
         rem = rem << 1;
         gi  = gi << 1;
         if (rem >= g) begin
            rem = rem - g;
            gi  = gi | 64'd1;
         end
      end
      return CW'(gi);
   endfunction

   localparam logic signed [CW-1:0] GAIN_INV = build_gain_inv();

endpackage

[design/haversine_distance_unit.sv]
`timescale 1ns / 1ps

// Great-circle distance by the haversine formula, fully pipelined: one point
// pair per clock while the response is not stalled. Most of the pipeline depth
// lies in the two 24-stage CORDIC chains (sine/cosine, then atan2) and the
// 31-stage bit-per-stage square root. Coordinates are signed, in units
// of 2^-22 degree; the distance is meters with 4 fraction bits, saturating at
// 421657428. The radius register (whole meters) may be written only while no
// beat is in flight. A stalled response freezes the whole pipe.
module haversine_distance_unit
   import hav_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [29:0]  req_first_latitude,
   input  logic signed [30:0]  req_first_longitude,
   input  logic signed [29:0]  req_second_latitude,
   input  logic signed [30:0]  req_second_longitude,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [28:0]         rsp_distance,
   input  logic                csr_wr_en,
   input  logic [22:0]         csr_wr_data
);

   logic             en;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [22:0]      radius_ff, radius_in;

   assign en        = ~(vld_ff[DEPTH-1] & rsp_stall);
   assign req_stall = ~en;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_comb begin
      vld_in    = en ? {vld_ff[DEPTH-2:0], req_valid} : vld_ff;
      radius_in = csr_wr_en ? csr_wr_data : radius_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= RADIUS_RESET;
      end else begin
         vld_ff    <= vld_in;
         radius_ff <= radius_in;
      end
   end

   // ---------------- angle reduction ----------------
   logic signed [33:0] ang [4];
   logic [31:0]        vmod_ff [4], vmod_in [4];
   quad_type           q2_ff [4], q2_in [4];
   logic [29:0]        rem_ff [4], rem_in [4];
   quad_type           q3_ff [4];
   logic signed [CW-1:0] z0_ff [4], z0_in [4];
   logic [62:0]        zprod [4];
   logic [62:0]        zsum [4];

   always_comb begin
      ang[LANE_LAT1] = {{3{req_first_latitude[29]}}, req_first_latitude, 1'b0};
      ang[LANE_LAT2] = {{3{req_second_latitude[29]}}, req_second_latitude, 1'b0};
      ang[LANE_DLAT] = {{4{req_second_latitude[29]}}, req_second_latitude}
                     - {{4{req_first_latitude[29]}}, req_first_latitude};
      ang[LANE_DLON] = {{3{req_second_longitude[30]}}, req_second_longitude}
                     - {{3{req_first_longitude[30]}}, req_first_longitude};
      for (int l = 0; l < 4; l++) begin
         if (ang[l][33]) vmod_in[l] = 32'(ang[l] + {2'b00, TURN_U23});
         else vmod_in[l] = ang[l][31:0];
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (vmod_ff[l] >= 32'(3 * QUARTER_U23)) begin
            q2_in[l]  = QUAD_3;
            rem_in[l] = 30'(vmod_ff[l] - 32'(3 * QUARTER_U23));
         end else if (vmod_ff[l] >= 32'(2 * QUARTER_U23)) begin
            q2_in[l]  = QUAD_2;
            rem_in[l] = 30'(vmod_ff[l] - 32'(2 * QUARTER_U23));
         end else if (vmod_ff[l] >= QUARTER_U23) begin
            q2_in[l]  = QUAD_1;
            rem_in[l] = 30'(vmod_ff[l] - QUARTER_U23);
         end else begin
            q2_in[l]  = QUAD_0;
            rem_in[l] = vmod_ff[l][29:0];
         end
      end
   end

   // degrees (2^-23) to radians Q40, rounded
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         zprod[l] = 63'(rem_ff[l]) * 63'(ANG_M);
         zsum[l]  = zprod[l] + 63'd1048576;
         z0_in[l] = CW'(zsum[l][62:21]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vmod_ff <= vmod_in;
         q2_ff   <= q2_in;
         rem_ff  <= rem_in;
         q3_ff   <= q2_ff;
         z0_ff   <= z0_in;
      end
   end

   // ---------------- rotation CORDIC, four lanes ----------------
   logic signed [CW-1:0] rx_ff [ITERS][4];
   logic signed [CW-1:0] ry_ff [ITERS][4];
   logic signed [CW-1:0] rz_ff [ITERS-1][4];
   quad_type             rq_ff [ITERS][4];

   for (genvar g = 0; g < ITERS; g++) begin : g_rot
      for (genvar l = 0; l < 4; l++) begin : g_lane
         logic signed [CW-1:0] xi, yi, zi;
         logic signed [CW-1:0] x_in, y_in, z_in;
         quad_type             qi;
         if (g == 0) begin : g_head
            assign xi = GAIN_INV;
            assign yi = '0;
            assign zi = z0_ff[l];
            assign qi = q3_ff[l];
         end else begin : g_body
            assign xi = rx_ff[g-1][l];
            assign yi = ry_ff[g-1][l];
            assign zi = rz_ff[g-1][l];
            assign qi = rq_ff[g-1][l];
         end
         always_comb begin
            if (zi >= 0) begin
               x_in = xi - (yi >>> g);
               y_in = yi + (xi >>> g);
               z_in = zi - ATAN_TAB[g];
            end else begin
               x_in = xi + (yi >>> g);
               y_in = yi - (xi >>> g);
               z_in = zi + ATAN_TAB[g];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rx_ff[g][l] <= x_in;
               ry_ff[g][l] <= y_in;
               rq_ff[g][l] <= qi;
            end
         end
         if (g < ITERS - 1) begin : g_zreg
            always_ff @(posedge clock) begin
               if (en) rz_ff[g][l] <= z_in;
            end
         end
      end
   end

   // ---------------- round to Q30, quadrant unfold ----------------
   logic signed [QW-1:0] cr [4], sr [4], co [4], si [4];
   logic signed [QW-1:0] c1_ff, c2_ff, sd_ff, sl_ff;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         cr[l] = QW'((rx_ff[ITERS-1][l] + 46'sd512) >>> 10);
         sr[l] = QW'((ry_ff[ITERS-1][l] + 46'sd512) >>> 10);
         case (rq_ff[ITERS-1][l])
            QUAD_0: begin
               co[l] = cr[l];
               si[l] = sr[l];
            end
            QUAD_1: begin
               co[l] = -sr[l];
               si[l] = cr[l];
            end
            QUAD_2: begin
               co[l] = -cr[l];
               si[l] = -sr[l];
            end
            default: begin
               co[l] = sr[l];
               si[l] = -cr[l];
            end
         endcase
      end
   end

   // ---------------- haversine term ----------------
   logic signed [2*QW-1:0] p_hs, p_hl, p_cc, p_t;
   logic signed [QW-1:0]   hs_ff, hl_ff, cc_ff, hs2_ff, t_ff;
   logic signed [QW:0]     asum;
   logic [30:0]            a_ff, a_in;

   always_comb begin
      p_hs = sd_ff * sd_ff;
      p_hl = sl_ff * sl_ff;
      p_cc = c1_ff * c2_ff;
      p_t  = cc_ff * hl_ff;
      asum = {hs2_ff[QW-1], hs2_ff} + {t_ff[QW-1], t_ff};
      if (asum < 0) a_in = '0;
      else if (asum > $signed({4'b0000, ONE_Q30})) a_in = ONE_Q30;
      else a_in = asum[30:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff  <= co[LANE_LAT1];
         c2_ff  <= co[LANE_LAT2];
         sd_ff  <= si[LANE_DLAT];
         sl_ff  <= si[LANE_DLON];
         hs_ff  <= QW'(p_hs >>> 30);
         hl_ff  <= QW'(p_hl >>> 30);
         cc_ff  <= QW'(p_cc >>> 30);
         hs2_ff <= hs_ff;
         t_ff   <= QW'(p_t >>> 30);
         a_ff   <= a_in;
      end
   end

   // ---------------- floor square roots of a and 1-a (Q60 in) ----------------
   logic [SQW-1:0] sv_ff [SQ_STEPS-1][2];
   logic [SQW-1:0] sr_ff [SQ_STEPS][2];

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam logic [SQW-1:0] BIT = SQW'(1) << (60 - 2 * j);
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [SQW-1:0] vi, ri, trial, v_in, r_in;
         if (j == 0) begin : g_head
            if (l == 0) begin : g_a
               assign vi = SQW'({a_ff, 30'b0});
            end else begin : g_b
               assign vi = SQW'({31'(ONE_Q30 - a_ff), 30'b0});
            end
            assign ri = '0;
         end else begin : g_body
            assign vi = sv_ff[j-1][l];
            assign ri = sr_ff[j-1][l];
         end
         always_comb begin
            trial = ri + BIT;
            if (vi >= trial) begin
               v_in = vi - trial;
               r_in = (ri >> 1) + BIT;
            end else begin
               v_in = vi;
               r_in = ri >> 1;
            end
         end
         always_ff @(posedge clock) begin
            if (en) sr_ff[j][l] <= r_in;
         end
         if (j < SQ_STEPS - 1) begin : g_vreg
            always_ff @(posedge clock) begin
               if (en) sv_ff[j][l] <= v_in;
            end
         end
      end
   end

   // ---------------- vectoring CORDIC: half central angle ----------------
   logic signed [CW-1:0] vx_ff [ITERS-1];
   logic signed [CW-1:0] vy_ff [ITERS-1];
   logic signed [CW-1:0] vz_ff [ITERS];

   for (genvar g = 0; g < ITERS; g++) begin : g_vec
      logic signed [CW-1:0] xi, yi, zi;
      logic signed [CW-1:0] x_in, y_in, z_in;
      if (g == 0) begin : g_head
         assign xi = CW'({sr_ff[SQ_STEPS-1][1][30:0], 10'b0});
         assign yi = CW'({sr_ff[SQ_STEPS-1][0][30:0], 10'b0});
         assign zi = '0;
      end else begin : g_body
         assign xi = vx_ff[g-1];
         assign yi = vy_ff[g-1];
         assign zi = vz_ff[g-1];
      end
      always_comb begin
         if (yi >= 0) begin
            x_in = xi + (yi >>> g);
            y_in = yi - (xi >>> g);
            z_in = zi + ATAN_TAB[g];
         end else begin
            x_in = xi - (yi >>> g);
            y_in = yi + (xi >>> g);
            z_in = zi - ATAN_TAB[g];
         end
      end
      always_ff @(posedge clock) begin
         if (en) vz_ff[g] <= z_in;
      end
      if (g < ITERS - 1) begin : g_xyreg
         always_ff @(posedge clock) begin
            if (en) begin
               vx_ff[g] <= x_in;
               vy_ff[g] <= y_in;
            end
         end
      end
   end

   // ---------------- scale by radius, round, saturate ----------------
   logic [41:0] zc;
   logic [43:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [65:0] dsum;
   logic [31:0] dval;
   logic [28:0] dist_ff, dist_in;

   always_comb begin
      // negative angle clamps to zero; z/2 split 21+21 bits for the multiply
      zc     = vz_ff[ITERS-1][CW-1] ? '0 : vz_ff[ITERS-1][42:1];
      plo_in = 44'(zc[20:0]) * 44'(radius_ff);
      phi_in = 44'(zc[41:21]) * 44'(radius_ff);
      dsum   = {1'b0, phi_ff, 21'b0} + 66'(plo_ff) + 66'h2_0000_0000;
      dval   = dsum[65:34];
      dist_in = (dval > {3'b000, DIST_MAX}) ? DIST_MAX : dval[28:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_distance = dist_ff;

   // ---------------- assertions ----------------
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance <= DIST_MAX)
      else $error("distance above saturation limit");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted beat not tracked in pipeline");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import hav_pkg::*;

   // Distance predictor plus the queue of distances still owed by the pipe.
   class distance_board;
      longint arctan_q40 [ITERS];
      longint inv_gain;
      longint unsigned radius;
      logic [28:0] owed [$];
      int errors;

      function new();
         longint unsigned pos, neg, term, g, rem;
         longint x, y, nx;
         int e;
         arctan_q40[0] = longint'((PI_Q60 + 64'd2097152) >> 22);
         for (int i = 1; i < ITERS; i++) begin
            pos = 0;
            neg = 0;
            for (int k = 0; ; k++) begin
               e = i * (2 * k + 1);
               if (e > 60) break;
               term = (64'd1 << (60 - e)) / longint'(2 * k + 1);
               if (k & 1) neg += term;
               else pos += term;
            end
            arctan_q40[i] = longint'((pos - neg + 64'd524288) >> 20);
         end
         x = 64'sd1 <<< 40;
         y = 0;
         for (int i = 0; i < ITERS; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
            end
            x = nx;
         end
         g = x;
         rem = 64'd1 << 40;
         inv_gain = 0;
         for (int i = 0; i < 40; i++) begin
            rem = rem << 1;
            inv_gain = inv_gain << 1;
            if (rem >= g) begin
               rem -= g;
               inv_gain |= 1;
            end
         end
         radius = RADIUS_RESET;
         errors = 0;
      endfunction

      // angle in 2^-23 degree -> cosine, sine in Q30
      function void trig_q30(input longint ang, output longint co, output longint si);
         longint v, r, z, x, y, nx, c, s;
         longint unsigned m;
         quad_type q;
         m = (PI_Q60 >> 22) / 180;
         v = ang % longint'(TURN_U23);
         if (v < 0) v += longint'(TURN_U23);
         q = quad_type'(v / longint'(QUARTER_U23));
         r = v - longint'(q) * longint'(QUARTER_U23);
         z = longint'((longint'(unsigned'(r)) * m + 64'd1048576) >> 21);
         x = inv_gain;
         y = 0;
         for (int i = 0; i < ITERS; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= arctan_q40[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += arctan_q40[i];
            end
            x = nx;
         end
         c = (x + 512) >>> 10;
         s = (y + 512) >>> 10;
         case (q)
            QUAD_0: begin co = c; si = s; end
            QUAD_1: begin co = -s; si = c; end
            QUAD_2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
         endcase
      endfunction

      function longint unsigned floor_root(input longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function void note_request(input longint lat1, input longint lon1,
                                 input longint lat2, input longint lon2);
         longint c1, s1, c2, s2, cd, sd, cl, sl, hs, hl, cc, a, x, y, nx, z;
         longint unsigned sa, sb, dist_val;
         trig_q30(2 * lat1, c1, s1);
         trig_q30(2 * lat2, c2, s2);
         trig_q30(lat2 - lat1, cd, sd);
         trig_q30(lon2 - lon1, cl, sl);
         hs = (sd * sd) >>> 30;
         hl = (sl * sl) >>> 30;
         cc = (c1 * c2) >>> 30;
         a = hs + ((cc * hl) >>> 30);
         if (a < 0) a = 0;
         if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
         sa = floor_root(longint'(unsigned'(a)) << 30);
         sb = floor_root(longint'(unsigned'((64'sd1 <<< 30) - a)) << 30);
         x = longint'(sb << 10);
         y = longint'(sa << 10);
         z = 0;
         for (int i = 0; i < ITERS; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += arctan_q40[i];
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= arctan_q40[i];
            end
            x = nx;
         end
         if (z < 0) z = 0;
         dist_val = ((longint'(unsigned'(2 * z)) >> 2) * radius + (64'd1 << 33)) >> 34;
         if (dist_val > DIST_MAX) dist_val = DIST_MAX;
         owed.push_back(dist_val[28:0]);
      endfunction

      function void check_distance(input logic [28:0] got);
         logic [28:0] want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected distance beat %0d", $time, got);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got !== want) begin
            $display("%0t: distance mismatch expected %0d actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [29:0] req_first_latitude, req_second_latitude;
   logic signed [30:0] req_first_longitude, req_second_longitude;
   logic rsp_valid, rsp_stall;
   logic [28:0] rsp_distance;
   logic csr_wr_en;
   logic [22:0] csr_wr_data;

   distance_board board;
   int send_idle_pct, stall_pct;
   bit hold_request;
   int hold_left;
   int quiet_cycles;

   localparam longint DEG = 4194304;
   localparam longint LAT_SPAN = 377487360;
   localparam longint LON_SPAN = 754974720;

   haversine_distance_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_latitude(req_first_latitude),
      .req_first_longitude(req_first_longitude),
      .req_second_latitude(req_second_latitude),
      .req_second_longitude(req_second_longitude),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_distance(rsp_distance),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_distance(rsp_distance);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 5000) begin
         $display("haversine_distance_unit regression: fail");
         $finish;
      end
   end

   task automatic send_pair(input longint lat1, input longint lon1,
                            input longint lat2, input longint lon2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_latitude <= lat1[29:0];
      req_first_longitude <= lon1[30:0];
      req_second_latitude <= lat2[29:0];
      req_second_longitude <= lon2[30:0];
      do @(posedge clock); while (req_stall);
      board.note_request(longint'(req_first_latitude), longint'(req_first_longitude),
                         longint'(req_second_latitude), longint'(req_second_longitude));
   endtask

   // pipe is empty once nothing is owed: every beat yields a distance
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() > 0) @(posedge clock);
   endtask

   task automatic write_radius(input logic [22:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.radius = value;
   endtask

   function automatic longint pick_lat();
      if ($urandom_range(9) < 2) return longint'($signed($urandom_range(32'h3fffffff) << 2)) >>> 2;
      return longint'($urandom_range(2 * LAT_SPAN)) - LAT_SPAN;
   endfunction

   function automatic longint pick_lon();
      if ($urandom_range(9) < 2) return longint'($signed($urandom() << 1)) >>> 1;
      return longint'($urandom_range(2 * LON_SPAN)) - LON_SPAN;
   endfunction

   task automatic random_pairs(input int count);
      longint lat1, lon1;
      for (int n = 0; n < count; n++) begin
         lat1 = pick_lat();
         lon1 = pick_lon();
         case ($urandom_range(3))
            // nearby points exercise the tiny-angle end
            0: send_pair(lat1, lon1, lat1 + $signed($urandom_range(2000)) - 1000,
                         lon1 + $signed($urandom_range(2000)) - 1000);
            // near-antipodal points push the clamp of the haversine term
            1: send_pair(lat1, lon1, -lat1 + $signed($urandom_range(64)) - 32,
                         lon1 + LON_SPAN + $signed($urandom_range(64)) - 32);
            default: send_pair(lat1, lon1, pick_lat(), pick_lon());
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_latitude = '0;
      req_first_longitude = '0;
      req_second_latitude = '0;
      req_second_longitude = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 0;
      hold_left = 0;
      quiet_cycles = 0;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of the fields, poles, date line, wrapped angles
      send_pair(0, 0, 0, 0);
      send_pair(LAT_SPAN, 0, -LAT_SPAN, 0);
      send_pair(0, -LON_SPAN, 0, LON_SPAN);
      send_pair(0, 0, 0, LON_SPAN);
      send_pair(LAT_SPAN, LON_SPAN, LAT_SPAN, -LON_SPAN);
      send_pair(45 * DEG, 10 * DEG, -45 * DEG, -170 * DEG);
      send_pair(-(64'sd1 <<< 29), -(64'sd1 <<< 30), (64'sd1 <<< 29) - 1, (64'sd1 <<< 30) - 1);
      send_pair((64'sd1 <<< 29) - 1, (64'sd1 <<< 30) - 1, -(64'sd1 <<< 29), -(64'sd1 <<< 30));
      send_pair(100 * DEG, 200 * DEG, -100 * DEG, -200 * DEG);
      send_pair(0, 0, 1, 1);
      send_pair(51 * DEG, 0, 40 * DEG, -74 * DEG);
      send_pair(-1, -1, 0, 0);
      drain();
      write_radius(23'd8388607);
      send_pair(0, 0, 0, LON_SPAN);
      send_pair(LAT_SPAN, 0, -LAT_SPAN, 0);
      send_pair(10 * DEG, 20 * DEG, -10 * DEG, -160 * DEG);
      drain();
      write_radius(23'd0);
      send_pair(0, 0, 0, LON_SPAN);
      send_pair(30 * DEG, 5 * DEG, -20 * DEG, 90 * DEG);
      drain();
      write_radius(23'd1);
      send_pair(0, 0, 0, LON_SPAN);
      send_pair(0, 0, 1000, 1000);
      drain();
      write_radius(RADIUS_RESET);

      random_pairs(200);
      drain();
      write_radius(23'($urandom_range(1, 8388607)));
      send_idle_pct = 67;
      random_pairs(200);
      drain();
      write_radius(23'd8388607);
      send_idle_pct = 0;
      stall_pct = 67;
      random_pairs(100);
      // long receiver hold-off while the sender keeps offering beats
      hold_request = 1;
      stall_pct = 0;
      random_pairs(100);
      drain();
      write_radius(23'($urandom_range(1, 200000)));
      send_idle_pct = 36;
      stall_pct = 36;
      random_pairs(230);

      drain();
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("haversine_distance_unit regression: pass");
      else
         $display("haversine_distance_unit regression: fail");
      $finish;
   end

endmodule

[sim.f]
design/hav_pkg.sv
design/haversine_distance_unit.sv
tb/sv/testbench.sv
